[sv/sigmoid_silu_activation_defines.svh]
// Assertion macros for the sigmoid / SiLU activation block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SIGMOID_SILU_ACTIVATION_DEFINES_SVH
`define SIGMOID_SILU_ACTIVATION_DEFINES_SVH

// same-cycle implication
`define SSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sigsilu_pkg.sv]
// Shared types, widths and knot-table generator functions for the activation block.
// No dependencies.
`default_nettype none

package sigsilu_pkg;

	localparam int SAMPLE_W = 16;	// Q8.8 input and SiLU result
	localparam int SIG_W    = 16;	// sigmoid, Q0.16
	localparam int KNOT_W   = 17;	// knot values, up to 65536
	localparam int SLOPE_W  = 16;	// difference of adjacent knots
	localparam int ACT_W    = 17;
	localparam int FRAC_W   = 11;	// |v| < 8.0 in Q8.8 is below 2^11
	localparam int STAGES   = 6;

	localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

	// s1 in bit 0
	typedef struct packed {
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} stage_en_t;

	// e^-x in Q31 from a truncated 25-term series, x = xq in Q31
	function automatic logic [63:0] taylor_r(input logic [63:0] xq);
		logic [63:0] term;
		longint      sum;
		term = ONE_Q31;
		sum  = longint'(ONE_Q31);
		for (int n = 1; n <= 24; n++) begin
			term = ((term * xq) >> 31) / 64'(n);
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q31))
			sum = longint'(ONE_Q31);
		return 64'(sum);
	endfunction

	// r^k in Q31 with rounding at every step
	function automatic logic [63:0] exp_knot(input logic [63:0] r, input int k);
		logic [63:0] e;
		e = ONE_Q31;
		for (int j = 1; j <= k; j++)
			e = (e * r + (64'd1 << 30)) >> 31;
		return e;
	endfunction

endpackage

`default_nettype wire

[sv/sigsilu_knot_rom.sv]
// Sigmoid knot table built at elaboration, with a registered read of a knot
// and the slope to the next one. Depends on sigsilu_pkg.
`default_nettype none

module sigsilu_knot_rom #(
	parameter int SEGMENTS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [$clog2(SEGMENTS)-1:0]   seg,
	output logic [sigsilu_pkg::KNOT_W-1:0]     base_s2,
	output logic [sigsilu_pkg::SLOPE_W-1:0]    slope_s2
);
	import sigsilu_pkg::*;

	localparam int          KNOT_IDX_W = $clog2(SEGMENTS + 1);
	localparam logic [63:0] XQ         = (64'd8 << 31) / SEGMENTS;
	localparam logic [63:0] R_STEP     = taylor_r(XQ);

	logic [KNOT_W-1:0]     knot [SEGMENTS+1];
	logic [KNOT_IDX_W-1:0] lo_idx;
	logic [KNOT_IDX_W-1:0] hi_idx;
	logic [KNOT_W-1:0]     knot_delta;

	// knot k = 1 / (1 + e^(-8k/SEGMENTS)) in Q0.16, rounded
	for (genvar k = 0; k <= SEGMENTS; k++) begin : g_knot
		localparam logic [63:0] D = ONE_Q31 + exp_knot(R_STEP, k);
		localparam logic [63:0] T = ((64'd1 << 47) + (D >> 1)) / D;
		assign knot[k] = T[KNOT_W-1:0];
	end

	assign lo_idx     = KNOT_IDX_W'(seg);
	assign hi_idx     = lo_idx + KNOT_IDX_W'(1);
	assign knot_delta = knot[hi_idx] - knot[lo_idx];

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2  <= knot[lo_idx];
			slope_s2 <= knot_delta[SLOPE_W-1:0];
		end
	end

endmodule

`default_nettype wire

[sv/sigsilu_sigmoid.sv]
// Stages 1 to 4: bias add, magnitude split, knot lookup, interpolation and
// sign mirroring. Depends on sigsilu_pkg and sigsilu_knot_rom.
`default_nettype none

module sigsilu_sigmoid #(
	parameter int SEGMENTS = 64
) (
	input  wire logic                                 clk,
	input  wire sigsilu_pkg::stage_en_t               en,
	input  wire logic [sigsilu_pkg::SAMPLE_W-1:0]     sample,
	input  wire logic [sigsilu_pkg::SAMPLE_W-1:0]     row_bias,
	output logic signed [sigsilu_pkg::SAMPLE_W-1:0]   v_s4,
	output logic [sigsilu_pkg::SIG_W-1:0]             sig_s4
);
	import sigsilu_pkg::*;

	localparam int SEG_W = $clog2(SEGMENTS);
	localparam int P_W   = FRAC_W + SEG_W;

	// stage 1
	logic [SAMPLE_W:0]          bias_sum;
	logic [SAMPLE_W-1:0]        v_next;
	logic signed [SAMPLE_W-1:0] v_s1;

	assign bias_sum = {sample[SAMPLE_W-1], sample} + {row_bias[SAMPLE_W-1], row_bias};

	always_comb begin
		v_next = bias_sum[SAMPLE_W-1:0];
		if (bias_sum[SAMPLE_W] != bias_sum[SAMPLE_W-1])
			v_next = bias_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                            : {1'b0, {(SAMPLE_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (en.s1)
			v_s1 <= $signed(v_next);
	end

	// stage 2: |v| split into segment and fraction
	logic [SAMPLE_W:0]          mag;
	logic                       beyond;
	logic [P_W-1:0]             pos;
	logic signed [SAMPLE_W-1:0] v_s2;
	logic [FRAC_W-1:0]          frac_s2;
	logic                       beyond_s2;
	logic [KNOT_W-1:0]          base_s2;
	logic [SLOPE_W-1:0]         slope_s2;

	assign mag    = v_s1[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {v_s1[SAMPLE_W-1], v_s1})
	                                 : {1'b0, v_s1};
	assign beyond = |mag[SAMPLE_W:FRAC_W];
	assign pos    = P_W'(mag[FRAC_W-1:0]) * P_W'(SEGMENTS);

	sigsilu_knot_rom #(
		.SEGMENTS(SEGMENTS)
	) u_rom (
		.clk     (clk),
		.en      (en.s2),
		.seg     (pos[P_W-1:FRAC_W]),
		.base_s2 (base_s2),
		.slope_s2(slope_s2)
	);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			v_s2      <= v_s1;
			frac_s2   <= pos[FRAC_W-1:0];
			beyond_s2 <= beyond;
		end
	end

	// stage 3: linear interpolation between knots
	localparam int RAMP_W = SLOPE_W + FRAC_W + 1;

	logic [RAMP_W-1:0]          ramp;
	logic [KNOT_W:0]            interp;
	logic signed [SAMPLE_W-1:0] v_s3;
	logic                       beyond_s3;
	logic [KNOT_W:0]            pos_sig_s3;

	assign ramp   = RAMP_W'(slope_s2) * RAMP_W'(frac_s2) + RAMP_W'(1 << (FRAC_W - 1));
	assign interp = (KNOT_W+1)'(base_s2) + (KNOT_W+1)'(ramp[RAMP_W-1:FRAC_W]);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			v_s3       <= v_s2;
			beyond_s3  <= beyond_s2;
			pos_sig_s3 <= interp;
		end
	end

	// stage 4: symmetry for negative v, saturation
	logic [KNOT_W:0]  mirrored;
	logic [KNOT_W:0]  raw;
	logic [SIG_W-1:0] sig_next;

	assign mirrored = (KNOT_W+1)'(1 << SIG_W) - pos_sig_s3;

	always_comb begin
		raw = v_s3[SAMPLE_W-1] ? mirrored : pos_sig_s3;
		if (beyond_s3)
			sig_next = v_s3[SAMPLE_W-1] ? '0 : '1;
		else if (|raw[KNOT_W:SIG_W])
			sig_next = '1;
		else
			sig_next = raw[SIG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			v_s4   <= v_s3;
			sig_s4 <= sig_next;
		end
	end

endmodule

`default_nettype wire

[sv/sigsilu_silu.sv]
// Stages 5 and 6: v times sigmoid, rounding, saturation and mode select.
// Depends on sigsilu_pkg.
`default_nettype none

module sigsilu_silu (
	input  wire logic                                 clk,
	input  wire sigsilu_pkg::stage_en_t               en,
	input  wire logic                                 silu_mode,
	input  wire logic signed [sigsilu_pkg::SAMPLE_W-1:0] v_s4,
	input  wire logic [sigsilu_pkg::SIG_W-1:0]        sig_s4,
	output logic [sigsilu_pkg::ACT_W-1:0]             act_s6
);
	import sigsilu_pkg::*;

	localparam int PROD_W = SAMPLE_W + SIG_W + 1;
	localparam int RND_W  = PROD_W + 1;
	localparam int SCL_W  = RND_W - SIG_W;

	// stage 5
	logic signed [PROD_W-1:0] prod_s5;
	logic [SIG_W-1:0]         sig_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			prod_s5 <= v_s4 * $signed({1'b0, sig_s4});
			sig_s5  <= sig_s4;
		end
	end

	// stage 6: round half up, floor shift, clamp to Q8.8
	logic signed [RND_W-1:0] rounded;
	logic [SCL_W-1:0]        scaled;
	logic [SAMPLE_W-1:0]     silu_val;
	logic [ACT_W-1:0]        act_next;

	assign rounded = $signed({prod_s5[PROD_W-1], prod_s5}) + RND_W'(1 << (SIG_W - 1));
	assign scaled  = rounded[RND_W-1:SIG_W];

	always_comb begin
		if ((&scaled[SCL_W-1:SAMPLE_W-1]) || !(|scaled[SCL_W-1:SAMPLE_W-1]))
			silu_val = scaled[SAMPLE_W-1:0];
		else
			silu_val = scaled[SCL_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                           : {1'b0, {(SAMPLE_W-1){1'b1}}};
		act_next = silu_mode ? {silu_val[SAMPLE_W-1], silu_val} : {1'b0, sig_s5};
	end

	always_ff @(posedge clk) begin
		if (en.s6)
			act_s6 <= act_next;
	end

endmodule

`default_nettype wire

[sv/sigmoid_silu_activation.sv]
// Sigmoid / SiLU activation unit: top level with stall control and mode register.
// Depends on sigsilu_pkg, sigsilu_sigmoid, sigsilu_silu and the defines header.
//
// Usage:
//   Input stream s_axis_*: one tensor element per item, sample and row bias
//   in tdata, end-of-row / end-of-tensor marks in tlast. Output stream m_axis_*:
//   activation in tdata (sigmoid Q0.16 unsigned, or SiLU Q8.8 signed and
//   sign-extended to 17 bits), marks echoed in tlast.
//   cfg_we / cfg_wdata set silu_mode (0 sigmoid, 1 SiLU); write only while
//   no item is in flight.
//   Each item passes through a six-stage pipeline (bias add, knot lookup,
//   interpolation, mirroring, multiply, round). Throughput: one item per
//   cycle while m_axis_tready stays high.
//   Stalls: each stage holds when its successor is full and stalled; empty
//   stages keep filling, so up to six items are buffered before s_axis_tready
//   drops. Nothing is dropped or repeated.
//   Reset: arst_n clears all stage valid bits and sets sigmoid mode.
`default_nettype none
`include "sigmoid_silu_activation_defines.svh"

module sigmoid_silu_activation #(
	parameter int SEGMENTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,	// [15:0] sample, [31:16] row_bias
	input  wire logic [1:0]  s_axis_tlast,	// [0] end_of_row, [1] end_of_tensor
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,	// [16:0] activation, [23:17] zero
	output logic [1:0]       m_axis_tlast,	// [0] row_done, [1] tensor_done
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata	// silu_mode
);
	import sigsilu_pkg::*;

	logic [STAGES-1:0]          valid_q;
	logic [STAGES-1:0]          row_q;
	logic [STAGES-1:0]          tensor_q;
	logic [STAGES-1:0]          stage_go;
	logic                       silu_q;
	stage_en_t                  en;
	logic signed [SAMPLE_W-1:0] v_s4;
	logic [SIG_W-1:0]           sig_s4;
	logic [ACT_W-1:0]           act_s6;
	logic                       in_fire;
	logic                       out_fire;

	// a stage loads when it is empty or its successor moves
	always_comb begin
		stage_go[STAGES-1] = !valid_q[STAGES-1] || m_axis_tready;
		for (int k = STAGES - 2; k >= 0; k--)
			stage_go[k] = !valid_q[k] || stage_go[k+1];
	end

	assign en = stage_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (stage_go & {valid_q[STAGES-2:0], s_axis_tvalid}) | (~stage_go & valid_q);
		end
	end

	always_ff @(posedge clk) begin
		row_q    <= (stage_go & {row_q[STAGES-2:0], s_axis_tlast[0]}) | (~stage_go & row_q);
		tensor_q <= (stage_go & {tensor_q[STAGES-2:0], s_axis_tlast[1]})
		            | (~stage_go & tensor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silu_q <= 1'b0;
		end else if (cfg_we) begin
			silu_q <= cfg_wdata;
		end
	end

	sigsilu_sigmoid #(
		.SEGMENTS(SEGMENTS)
	) u_sigmoid (
		.clk     (clk),
		.en      (en),
		.sample  (s_axis_tdata[15:0]),
		.row_bias(s_axis_tdata[31:16]),
		.v_s4    (v_s4),
		.sig_s4  (sig_s4)
	);

	sigsilu_silu u_silu (
		.clk      (clk),
		.en       (en),
		.silu_mode(silu_q),
		.v_s4     (v_s4),
		.sig_s4   (sig_s4),
		.act_s6   (act_s6)
	);

	assign s_axis_tready = stage_go[0];
	assign m_axis_tvalid = valid_q[STAGES-1];
	assign m_axis_tdata  = {7'd0, act_s6};
	assign m_axis_tlast  = {tensor_q[STAGES-1], row_q[STAGES-1]};

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	`SSA_ASSERT_NEXT(a_fill_count, clk, arst_n, in_fire && !out_fire, $countones(valid_q) == $past($countones(valid_q)) + 1, "item entered but occupancy did not grow")
	`SSA_ASSERT_NEXT(a_drain_count, clk, arst_n, out_fire && !in_fire, $countones(valid_q) + 1 == $past($countones(valid_q)), "item left but occupancy did not shrink")
	`SSA_ASSERT_NOW(a_full_stall, clk, arst_n, (&valid_q) && !m_axis_tready, !s_axis_tready, "pipeline full and stalled but input ready")

endmodule

`default_nettype wire
